/* hdl/randomized_rank_encoder_core_macros.svh */
// Assertion macros used by the rank encoder top level.
`ifndef RANDOMIZED_RANK_ENCODER_CORE_MACROS_SVH
`define RANDOMIZED_RANK_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RRE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/rre_pkg.sv */
// Shared types and constants for the randomized rank encoder.
`timescale 1ns / 1ps
package rre_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int DATA_W            = 32;
   localparam logic [DATA_W-1:0] ALL_ONES = '1;

   // One input item.
   typedef struct packed {
      logic signed [DATA_W-1:0] key_value;
      logic [DATA_W-1:0]        rand_word;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [DATA_W-1:0] rank_code;
      logic [DATA_W-1:0] key_count;
      logic              new_key;
      logic              table_full;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic scan;
      logic update;
      logic mult;
      logic out_load;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage

/* hdl/rre_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module rre_ram #(
   parameter int WIDTH = rre_pkg::DATA_W,
   parameter int DEPTH = rre_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/rre_datapath.sv */
// Datapath: key/count tables, scan accumulator, multiplier and result register.
`timescale 1ns / 1ps
module rre_datapath #(
   parameter int TABLE_ENTRIES = rre_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  rre_pkg::cmd_type    cmd,
   output rre_pkg::status_type status,
   input  rre_pkg::req_type    req_data,
   output rre_pkg::rsp_type    rsp_data
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int UW = $clog2(TABLE_ENTRIES + 1);
   localparam int DW = rre_pkg::DATA_W;

   // captured item
   logic signed [DW-1:0] key_ff;
   logic [DW-1:0]        rnd_ff;

   // scan state
   logic [UW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [IW-1:0] cmp_idx_ff;
   logic [UW-1:0] used_ff, used_in;
   logic [DW-1:0] prefix_ff, prefix_in;
   logic          found_ff, found_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic [DW-1:0] hit_cnt_ff, hit_cnt_in;

   // update / result
   logic [DW-1:0]   cnt_ff, cnt_in;
   logic            full_ff, full_in;
   logic [2*DW-1:0] prod_ff;
   rre_pkg::rsp_type rsp_ff, rsp_in;

   // memory ports
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [DW-1:0] key_rd, cnt_rd;
   logic          key_wr_en, cnt_wr_en;
   logic [IW-1:0] wr_addr;
   logic [DW-1:0] cnt_wr_data;

   logic          is_full;
   logic [DW:0]   prefix_sum;
   logic [DW:0]   rank_sum;
   logic [DW-1:0] cnt_inc;

   rre_ram #(.WIDTH(DW), .DEPTH(TABLE_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   rre_ram #(.WIDTH(DW), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (cnt_rd)
   );

   // scan: one entry read per cycle, compared in the next cycle
   assign rd_en      = cmd.scan && (rd_idx_ff < used_ff);
   assign rd_addr    = rd_idx_ff[IW-1:0];
   assign prefix_sum = {1'b0, prefix_ff} + {1'b0, cnt_rd};
   assign status.scan_done = (rd_idx_ff == used_ff) && !rd_pend_ff;

   always_comb begin
      rd_idx_in  = rd_idx_ff;
      rd_pend_in = rd_en;
      prefix_in  = prefix_ff;
      found_in   = found_ff;
      hit_idx_in = hit_idx_ff;
      hit_cnt_in = hit_cnt_ff;
      if (cmd.load) begin
         rd_idx_in = '0;
         prefix_in = '0;
         found_in  = 1'b0;
      end else begin
         if (rd_en) begin
            rd_idx_in = rd_idx_ff + UW'(1);
         end
         if (rd_pend_ff) begin
            if (key_rd == key_ff) begin
               found_in   = 1'b1;
               hit_idx_in = cmp_idx_ff;
               hit_cnt_in = cnt_rd;
            end else if ($signed(key_rd) < key_ff) begin
               prefix_in = prefix_sum[DW] ? rre_pkg::ALL_ONES : prefix_sum[DW-1:0];
            end
         end
      end
   end

   // table update: bump a hit count or insert a new key while the table has room
   assign is_full     = (used_ff == UW'(TABLE_ENTRIES));
   assign cnt_inc     = (hit_cnt_ff == rre_pkg::ALL_ONES) ? hit_cnt_ff
                                                          : hit_cnt_ff + DW'(1);
   assign key_wr_en   = cmd.update && !found_ff && !is_full;
   assign cnt_wr_en   = cmd.update && (found_ff || !is_full);
   assign wr_addr     = found_ff ? hit_idx_ff : used_ff[IW-1:0];
   assign cnt_wr_data = found_ff ? cnt_inc : DW'(1);

   always_comb begin
      used_in = used_ff;
      cnt_in  = cnt_ff;
      full_in = full_ff;
      if (cmd.update) begin
         cnt_in  = cnt_wr_data;
         full_in = !found_ff && is_full;
         if (key_wr_en) begin
            used_in = used_ff + UW'(1);
         end
      end
   end

   // final rank: prefix plus high half of rand*count, saturating
   assign rank_sum = {1'b0, prefix_ff} + {1'b0, prod_ff[2*DW-1:DW]};

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         if (full_ff) begin
            rsp_in            = '0;
            rsp_in.table_full = 1'b1;
         end else begin
            rsp_in.rank_code  = rank_sum[DW] ? rre_pkg::ALL_ONES : rank_sum[DW-1:0];
            rsp_in.key_count  = cnt_ff;
            rsp_in.new_key    = !found_ff;
            rsp_in.table_full = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         used_ff    <= used_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_data.key_value;
         rnd_ff <= req_data.rand_word;
      end
      if (cmd.mult) begin
         prod_ff <= (2*DW)'(rnd_ff) * (2*DW)'(cnt_ff);
      end
      cmp_idx_ff <= rd_addr;
      rd_idx_ff  <= rd_idx_in;
      prefix_ff  <= prefix_in;
      found_ff   <= found_in;
      hit_idx_ff <= hit_idx_in;
      hit_cnt_ff <= hit_cnt_in;
      cnt_ff     <= cnt_in;
      full_ff    <= full_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

/* hdl/rre_ctrl.sv */
// Controller: sequences scan, update, multiply and result hand-off per item.
`timescale 1ns / 1ps
module rre_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rre_pkg::cmd_type    cmd,
   input  rre_pkg::status_type status
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_MULT   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/randomized_rank_encoder_core.sv */
// Randomized rank encoder: top level joining controller and datapath.
// Each item is loaded when accepted, then passes through the scan, update,
// multiply and finish states before its result is loaded into the output
// register. The table scan reads one stored key and count per cycle through
// the single read port of the key and count memories, over the used entries
// (used = number of distinct keys stored, at most TABLE_ENTRIES). One item is
// worked on at a time; the next item is taken while a finished result still
// waits in the output register, and that next result then holds in the last
// state for as long as the earlier one stays stalled. No clearing pass runs
// after reset.
`timescale 1ns / 1ps
`include "randomized_rank_encoder_core_macros.svh"
module randomized_rank_encoder_core #(
   parameter int TABLE_ENTRIES = rre_pkg::TABLE_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rre_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rre_pkg::rsp_type rsp_data
);

   rre_pkg::cmd_type    cmd;
   rre_pkg::status_type status;

   rre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rre_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // checks
   `RRE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "accepted item did not make the block busy")
   `RRE_ASSERT_NOW(a_full_fields_zero, clock, reset, rsp_valid && rsp_data.table_full, rsp_data.rank_code == 0 && rsp_data.key_count == 0 && !rsp_data.new_key, "full-table result carries nonzero fields")
   `RRE_ASSERT_NOW(a_new_key_count_one, clock, reset, rsp_valid && rsp_data.new_key, rsp_data.key_count == 1 && !rsp_data.table_full, "new key result without count of one")
   `RRE_ASSERT_NOW(a_count_nonzero, clock, reset, rsp_valid && !rsp_data.table_full, rsp_data.key_count != 0, "stored key result with zero count")

endmodule
